/* src/ffha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, transaction types, header helpers and controller states.
// ----------------------------------------------------------------------------
package ffha_pkg;

	// Heap geometry and block header layout.
	localparam int HEAP_WORDS_MAX = 1024;
	localparam int ADDR_WORDS     = 1024;
	localparam int MERGE_LIMIT    = 10;
	localparam int LEN_CAP        = (HEAP_WORDS_MAX < ADDR_WORDS) ? HEAP_WORDS_MAX : ADDR_WORDS;
	localparam int IDX_W          = $clog2(HEAP_WORDS_MAX);
	localparam int SIZE_W         = 11;
	localparam int HDR_W          = SIZE_W + 1;
	localparam int POS_W          = 12;
	localparam int CNT_W          = $clog2(MERGE_LIMIT + 1);
	localparam int BYTE_W         = 12;

	// One request transaction.
	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] req_bytes;
		logic [BYTE_W-1:0] free_addr;
	} req_t;

	// One response transaction.
	typedef struct packed {
		logic [BYTE_W-1:0] addr;
		logic              ok;
	} rsp_t;

	// Operation codes carried in req_t.op.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Access request from the controller to the header memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [HDR_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_C_CHECK,
		ST_C_READ,
		ST_M_CHECK,
		ST_M_READ,
		ST_F_CHECK,
		ST_F_READ,
		ST_F_MARK,
		ST_R_CHECK,
		ST_R_READ,
		ST_RESP
	} state_t;

	// Build a header word from a size and an allocated mark.
	function automatic logic [HDR_W-1:0] mk_hdr(input logic [SIZE_W-1:0] size,
		input logic alloc);
		mk_hdr = {alloc, size};
	endfunction

	// Block size of a header; a zero size is treated as one word.
	function automatic logic [SIZE_W-1:0] blk_size(input logic [HDR_W-1:0] hdr);
		blk_size = (hdr[SIZE_W-1:0] == '0) ? SIZE_W'(1) : hdr[SIZE_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// An allocate first runs the coalescing pass: for at most MERGE_LIMIT blocks it reads the header,
// absorbs each free neighbor into a free block until its run stops at a used block or the heap
// end, and then walks the blocks by first fit. A free walks the block starts up to its header.
// One transaction is in flight at a time, and a held response stalls the next transaction in
// its response state until the held one is taken.
// Reset (asynchronous, active low) clears the controller and sets the heap size to zero.
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Implicit free-list allocator over a memory of block headers, with a bounded
// coalescing pass before each allocate.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ffha_pkg::req_t                req_data,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output ffha_pkg::rsp_t                     rsp_data,
	input  wire logic                          cfg_we,
	input  wire logic [ffha_pkg::SIZE_W-1:0]   cfg_data
);

	ffha_pkg::mem_req_t          mreq;
	logic [ffha_pkg::HDR_W-1:0]  rdata;

	// Walk controller.
	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.mreq      (mreq),
		.rdata     (rdata)
	);

	// Block header storage.
	ffha_hdr_ram u_hdr_ram (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

`ifndef SYNTHESIS
	// A failed transaction never reports an address.
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.ok) |-> (rsp_data.addr == '0))
		else $error("failed response carries a nonzero address");

	// Payload offsets are always word aligned.
	a_addr_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.addr[1:0] == 2'b00))
		else $error("response address is not word aligned");

	// Accepting a request makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request port still ready after an accepted transaction");
`endif

endmodule
`default_nettype wire

/* src/ffha_hdr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Header memory
// Single-write, single-read synchronous memory of block headers with a
// registered read port.
// ----------------------------------------------------------------------------
module ffha_hdr_ram (
	input  wire logic                        clk,
	input  wire ffha_pkg::mem_req_t          mreq,
	output logic [ffha_pkg::HDR_W-1:0]       rdata
);

	logic [ffha_pkg::HDR_W-1:0] mem_q [ffha_pkg::HEAP_WORDS_MAX];

	// Write port.
	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (mreq.re) begin
			rdata <= mem_q[mreq.raddr];
		end
	end

endmodule
`default_nettype wire

/* src/ffha_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the coalescing pass, the first-fit walk and the free lookup over
// the header memory, and holds the heap size and the response register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ffha_pkg::req_t                req_data,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output ffha_pkg::rsp_t                     rsp_data,
	input  wire logic                          cfg_we,
	input  wire logic [ffha_pkg::SIZE_W-1:0]   cfg_data,
	output ffha_pkg::mem_req_t                 mreq,
	input  wire logic [ffha_pkg::HDR_W-1:0]    rdata
);

	localparam int POS_W  = ffha_pkg::POS_W;
	localparam int SIZE_W = ffha_pkg::SIZE_W;
	localparam int IDX_W  = ffha_pkg::IDX_W;
	localparam int CNT_W  = ffha_pkg::CNT_W;
	localparam int BYTE_W = ffha_pkg::BYTE_W;

	ffha_pkg::state_t     state_q, state_d;
	logic [POS_W-1:0]     p_q, p_d;
	logic [POS_W-1:0]     n_q, n_d;
	logic [SIZE_W-1:0]    size_q, size_d;
	logic [SIZE_W-1:0]    need_q, need_d;
	logic [IDX_W-1:0]     h_q, h_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [SIZE_W-1:0]    heap_len_q;
	logic [BYTE_W-1:0]    res_addr_q, res_addr_d;
	logic                 res_ok_q, res_ok_d;
	logic                 rsp_valid_q;
	ffha_pkg::rsp_t       rsp_q;
	logic                 rsp_load;
	ffha_pkg::mem_req_t   walk_req;

	logic [SIZE_W-1:0]    cfg_len;
	logic [POS_W-1:0]     heap_end;
	logic                 hdr_alloc;
	logic [SIZE_W-1:0]    hdr_size;
	logic [IDX_W-1:0]     p_inc;

	// Clamp the configured heap size to the addressable range.
	assign cfg_len = (32'(cfg_data) > ffha_pkg::LEN_CAP) ? SIZE_W'(ffha_pkg::LEN_CAP) : cfg_data;

	assign heap_end  = POS_W'(heap_len_q);
	assign hdr_alloc = rdata[SIZE_W];
	assign hdr_size  = ffha_pkg::blk_size(rdata);
	assign p_inc     = p_q[IDX_W-1:0] + IDX_W'(1);

	assign req_ready = (state_q == ffha_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Configuration writes take the memory port; the user holds them to idle.
	always_comb begin
		mreq = walk_req;
		if (cfg_we) begin
			mreq.we    = (cfg_len != '0);
			mreq.waddr = '0;
			mreq.wdata = ffha_pkg::mk_hdr(cfg_len, 1'b0);
		end
	end

	// State register and walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q        <= p_d;
		n_q        <= n_d;
		size_q     <= size_d;
		need_q     <= need_d;
		h_q        <= h_d;
		cnt_q      <= cnt_d;
		res_addr_q <= res_addr_d;
		res_ok_q   <= res_ok_d;
	end

	// Heap size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_len_q <= '0;
		end else if (cfg_we) begin
			heap_len_q <= cfg_len;
		end
	end

	// Response register: it frees up as soon as the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.addr <= res_addr_q;
			rsp_q.ok   <= res_ok_q;
		end
	end

	// Next state, walk updates and memory accesses.
	always_comb begin
		state_d    = state_q;
		p_d        = p_q;
		n_d        = n_q;
		size_d     = size_q;
		need_d     = need_q;
		h_d        = h_q;
		cnt_d      = cnt_q;
		res_addr_d = res_addr_q;
		res_ok_d   = res_ok_q;
		rsp_load   = 1'b0;
		walk_req   = '0;

		case (state_q)
			ffha_pkg::ST_IDLE: begin
				res_addr_d = '0;
				res_ok_d   = 1'b0;
				p_d        = '0;
				if (req_valid) begin
					if (req_data.op == ffha_pkg::OP_ALLOC) begin
						need_d  = SIZE_W'((13'(req_data.req_bytes) + 13'd3) >> 2) + SIZE_W'(1);
						cnt_d   = CNT_W'(ffha_pkg::MERGE_LIMIT);
						state_d = ffha_pkg::ST_C_CHECK;
					end else if (req_data.free_addr == '0 || req_data.free_addr[1:0] != 2'b00) begin
						state_d = ffha_pkg::ST_RESP;
					end else begin
						h_d     = req_data.free_addr[BYTE_W-1:2] - IDX_W'(1);
						state_d = ffha_pkg::ST_R_CHECK;
					end
				end
			end

			// Coalescing pass: visit the next block if budget and heap remain.
			ffha_pkg::ST_C_CHECK: begin
				if (p_q < heap_end && cnt_q != '0) begin
					walk_req.re    = 1'b1;
					walk_req.raddr = p_q[IDX_W-1:0];
					state_d        = ffha_pkg::ST_C_READ;
				end else begin
					p_d     = '0;
					state_d = ffha_pkg::ST_F_CHECK;
				end
			end

			ffha_pkg::ST_C_READ: begin
				if (hdr_alloc) begin
					p_d     = p_q + POS_W'(hdr_size);
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = ffha_pkg::ST_C_CHECK;
				end else begin
					size_d  = hdr_size;
					n_d     = p_q + POS_W'(hdr_size);
					state_d = ffha_pkg::ST_M_CHECK;
				end
			end

			// Merge loop: look at the block after the growing free block.
			ffha_pkg::ST_M_CHECK: begin
				if (n_q < heap_end) begin
					walk_req.re    = 1'b1;
					walk_req.raddr = n_q[IDX_W-1:0];
					state_d        = ffha_pkg::ST_M_READ;
				end else begin
					walk_req.we    = 1'b1;
					walk_req.waddr = p_q[IDX_W-1:0];
					walk_req.wdata = ffha_pkg::mk_hdr(size_q, 1'b0);
					p_d            = p_q + POS_W'(ffha_pkg::blk_size(walk_req.wdata));
					cnt_d          = cnt_q - CNT_W'(1);
					state_d        = ffha_pkg::ST_C_CHECK;
				end
			end

			ffha_pkg::ST_M_READ: begin
				if (!hdr_alloc) begin
					size_d  = size_q + hdr_size;
					n_d     = n_q + POS_W'(hdr_size);
					state_d = ffha_pkg::ST_M_CHECK;
				end else begin
					walk_req.we    = 1'b1;
					walk_req.waddr = p_q[IDX_W-1:0];
					walk_req.wdata = ffha_pkg::mk_hdr(size_q, 1'b0);
					p_d            = p_q + POS_W'(ffha_pkg::blk_size(walk_req.wdata));
					cnt_d          = cnt_q - CNT_W'(1);
					state_d        = ffha_pkg::ST_C_CHECK;
				end
			end

			// First-fit walk.
			ffha_pkg::ST_F_CHECK: begin
				if (p_q < heap_end) begin
					walk_req.re    = 1'b1;
					walk_req.raddr = p_q[IDX_W-1:0];
					state_d        = ffha_pkg::ST_F_READ;
				end else begin
					state_d = ffha_pkg::ST_RESP;
				end
			end

			ffha_pkg::ST_F_READ: begin
				if (!hdr_alloc && hdr_size >= need_q) begin
					res_addr_d = {p_inc, 2'b00};
					res_ok_d   = 1'b1;
					walk_req.we = 1'b1;
					if (hdr_size > need_q) begin
						// Split: the remainder becomes a new free block.
						walk_req.waddr = IDX_W'(p_q + POS_W'(need_q));
						walk_req.wdata = ffha_pkg::mk_hdr(hdr_size - need_q, 1'b0);
						state_d        = ffha_pkg::ST_F_MARK;
					end else begin
						walk_req.waddr = p_q[IDX_W-1:0];
						walk_req.wdata = ffha_pkg::mk_hdr(hdr_size, 1'b1);
						state_d        = ffha_pkg::ST_RESP;
					end
				end else begin
					p_d     = p_q + POS_W'(hdr_size);
					state_d = ffha_pkg::ST_F_CHECK;
				end
			end

			ffha_pkg::ST_F_MARK: begin
				walk_req.we    = 1'b1;
				walk_req.waddr = p_q[IDX_W-1:0];
				walk_req.wdata = ffha_pkg::mk_hdr(need_q, 1'b1);
				state_d        = ffha_pkg::ST_RESP;
			end

			// Free lookup: walk block starts up to the target header.
			ffha_pkg::ST_R_CHECK: begin
				if (p_q < heap_end && p_q <= POS_W'(h_q)) begin
					walk_req.re    = 1'b1;
					walk_req.raddr = p_q[IDX_W-1:0];
					state_d        = ffha_pkg::ST_R_READ;
				end else begin
					state_d = ffha_pkg::ST_RESP;
				end
			end

			ffha_pkg::ST_R_READ: begin
				if (p_q == POS_W'(h_q)) begin
					walk_req.we    = 1'b1;
					walk_req.waddr = p_q[IDX_W-1:0];
					walk_req.wdata = ffha_pkg::mk_hdr(hdr_size, 1'b0);
					res_ok_d       = 1'b1;
					state_d        = ffha_pkg::ST_RESP;
				end else begin
					p_d     = p_q + POS_W'(hdr_size);
					state_d = ffha_pkg::ST_R_CHECK;
				end
			end

			// Hand the result to the response register once it is free.
			ffha_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ffha_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = ffha_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire
